/* hdl/mmot_pkg.sv */
// ----------------------------------------------------------------------------
// mmot_pkg
// Shared types, constants and controller/datapath interface structs for the
// median / MAD outlier threshold core.
// ----------------------------------------------------------------------------
package mmot_pkg;

  // Field widths
  localparam int VAL_W    = 24;
  localparam int K_W      = 16;
  localparam int K_FRAC   = 12;
  localparam int CNT_W    = 7;
  localparam int BIT_W    = 5;
  localparam int PROD_W   = K_W + VAL_W;

  // Capacity default
  localparam int MAX_SAMPLES_DEF = 64;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 2'd1;
  localparam logic [K_W-1:0]   SCALE_RST = 16'd15182;
  localparam logic [VAL_W-1:0] FLOOR_RST = 24'd256;

  // Top bit of a sample, first bit resolved by the selection passes
  localparam logic [BIT_W-1:0] TOP_BIT = 5'd23;

  // Input item
  typedef struct packed {
    logic [VAL_W-1:0] error_value;
    logic             has_value;
    logic             last;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [VAL_W-1:0] threshold;
    logic [VAL_W-1:0] median_value;
    logic [VAL_W-1:0] mad_value;
    logic [CNT_W-1:0] sample_count;
    logic             overflow;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             init;      // clear prefixes, load ranks
    logic             rd_en;     // read sample store
    logic             acc;       // count the returned sample
    logic             step;      // resolve one bit of both prefixes
    logic             set_med;   // latch median, restart for deviations
    logic             set_mad;   // latch MAD
    logic             mul;       // k * MAD
    logic             thr;       // saturate, apply floor
    logic             empty;     // empty set result
    logic             load_out;  // move result to output register, clear set
    logic             phase;     // 0: samples, 1: absolute deviations
    logic [BIT_W-1:0] bit_idx;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fill_zero;
    logic addr_last;
    logic out_free;
  } dp_sts_t;

endpackage

/* hdl/mmot_ram.sv */
// ----------------------------------------------------------------------------
// mmot_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mmot_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/mmot_ctrl.sv */
// ----------------------------------------------------------------------------
// mmot_ctrl
// Sequencer: loads samples, then runs the bitwise selection passes for the
// median and the MAD, the scaling steps and the result transfer.
// ----------------------------------------------------------------------------
module mmot_ctrl #(
  parameter int MAX_SAMPLES = mmot_pkg::MAX_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_last,
  output logic                           in_stall,
  input  mmot_pkg::dp_sts_t              sts,
  output mmot_pkg::dp_cmd_t              cmd,
  output logic [$clog2(MAX_SAMPLES)-1:0] rd_addr
);

  localparam int AW = $clog2(MAX_SAMPLES);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_PASS  = 4'd2;
  localparam logic [3:0] S_WAIT  = 4'd3;
  localparam logic [3:0] S_STEP  = 4'd4;
  localparam logic [3:0] S_MED   = 4'd5;
  localparam logic [3:0] S_MAD   = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_THR   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]                   state_r, state_nxt;
  logic [AW-1:0]                addr_r, addr_nxt;
  logic [mmot_pkg::BIT_W-1:0]   bit_r, bit_nxt;
  logic                         phase_r, phase_nxt;
  logic                         rdq_r, rdq_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    bit_nxt   = bit_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.phase   = phase_r;
    cmd.bit_idx = bit_r;
    cmd.acc     = rdq_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid && in_last) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (sts.fill_zero) begin
          cmd.empty = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.init  = 1'b1;
          addr_nxt  = '0;
          bit_nxt   = mmot_pkg::TOP_BIT;
          phase_nxt = 1'b0;
          state_nxt = S_PASS;
        end
      end
      S_PASS: begin
        cmd.rd_en = 1'b1;
        if (sts.addr_last) begin
          addr_nxt  = '0;
          state_nxt = S_WAIT;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_WAIT: begin
        // last read data is counted here
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (bit_r == '0) begin
          state_nxt = phase_r ? S_MAD : S_MED;
        end else begin
          bit_nxt   = bit_r - 1'b1;
          state_nxt = S_PASS;
        end
      end
      S_MED: begin
        cmd.set_med = 1'b1;
        phase_nxt   = 1'b1;
        bit_nxt     = mmot_pkg::TOP_BIT;
        state_nxt   = S_PASS;
      end
      S_MAD: begin
        cmd.set_mad = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_THR;
      end
      S_THR: begin
        cmd.thr   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  assign rdq_nxt  = cmd.rd_en;
  assign rd_addr  = addr_r;
  assign in_stall = (state_r != S_LOAD);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      addr_r  <= '0;
      bit_r   <= '0;
      phase_r <= 1'b0;
      rdq_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      bit_r   <= bit_nxt;
      phase_r <= phase_nxt;
      rdq_r   <= rdq_nxt;
    end
  end

endmodule

/* hdl/mmot_dp.sv */
// ----------------------------------------------------------------------------
// mmot_dp
// Datapath: sample store, fill count, configuration registers, two bitwise
// rank selectors, scaling, saturation and the output register.
// ----------------------------------------------------------------------------
module mmot_dp #(
  parameter int MAX_SAMPLES = mmot_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_accept,
  input  mmot_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mmot_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [mmot_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mmot_pkg::VAL_W-1:0]          cfg_wdata,
  input  mmot_pkg::dp_cmd_t                   cmd,
  input  logic [$clog2(MAX_SAMPLES)-1:0]      rd_addr,
  output mmot_pkg::dp_sts_t                   sts
);

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int VW    = mmot_pkg::VAL_W;
  localparam int PW    = mmot_pkg::PROD_W;
  localparam int NW    = mmot_pkg::CNT_W;
  localparam logic [CW-1:0] CAP = CW'(MAX_SAMPLES);

  logic [mmot_pkg::K_W-1:0] scale_r;
  logic [VW-1:0]            floor_r;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     ram_we;
  logic [VW-1:0]            rd_data;
  logic [CW-1:0]            fill_m1;

  logic [VW-1:0]            pre_lo_r, pre_hi_r;
  logic [CW-1:0]            rank_lo_r, rank_hi_r;
  logic [CW-1:0]            cnt_lo_r, cnt_hi_r;
  logic [VW-1:0]            med_r, mad_r, thr_r;
  logic [PW-1:0]            prod_r;

  logic [VW-1:0]            sel_val;
  logic [VW:0]              hi_mask_w;
  logic [VW-1:0]            hi_mask;
  logic [VW-1:0]            bit_one;
  logic                     hit_lo, hit_hi;
  logic [VW:0]              mid_sum;
  logic [VW+4:0]            thr_sum;
  logic [VW-1:0]            thr_sat;
  logic [CW+NW-1:0]         cnt_ext;
  logic                     out_valid_r;
  mmot_pkg::out_item_t      out_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= mmot_pkg::SCALE_RST;
      floor_r <= mmot_pkg::FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mmot_pkg::REG_SCALE: scale_r <= cfg_wdata[mmot_pkg::K_W-1:0];
        mmot_pkg::REG_FLOOR: floor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Fill count and overflow: store a sample, drop it when full, clear on transfer
  assign ram_we = in_accept && in_data.has_value && (fill_r < CAP);
  always_comb begin
    fill_nxt = fill_r;
    ovf_nxt  = ovf_r;
    if (cmd.load_out) begin
      fill_nxt = '0;
      ovf_nxt  = 1'b0;
    end else if (in_accept && in_data.has_value) begin
      if (fill_r < CAP) begin
        fill_nxt = fill_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  mmot_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_SAMPLES)
  ) u_sample_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_data.error_value),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Selection value: the sample, or its distance from the median
  assign sel_val = !cmd.phase ? rd_data :
                   (rd_data >= med_r) ? (rd_data - med_r) : (med_r - rd_data);

  // Match the resolved upper bits and test the current bit for zero
  assign hi_mask_w = {(VW+1){1'b1}} << ({1'b0, cmd.bit_idx} + 1'b1);
  assign hi_mask   = hi_mask_w[VW-1:0];
  assign bit_one   = {{(VW-1){1'b0}}, 1'b1} << cmd.bit_idx;
  assign hit_lo    = (((sel_val ^ pre_lo_r) & hi_mask) == '0) && !sel_val[cmd.bit_idx];
  assign hit_hi    = (((sel_val ^ pre_hi_r) & hi_mask) == '0) && !sel_val[cmd.bit_idx];

  assign fill_m1 = fill_r - 1'b1;
  assign mid_sum = {1'b0, pre_lo_r} + {1'b0, pre_hi_r};

  // Rank selectors for the lower and upper middle element
  always_ff @(posedge clk) begin
    if (cmd.init || cmd.set_med) begin
      pre_lo_r  <= '0;
      pre_hi_r  <= '0;
      rank_lo_r <= fill_m1 >> 1;
      rank_hi_r <= fill_r >> 1;
      cnt_lo_r  <= '0;
      cnt_hi_r  <= '0;
    end else if (cmd.step) begin
      if (rank_lo_r >= cnt_lo_r) begin
        pre_lo_r  <= pre_lo_r | bit_one;
        rank_lo_r <= rank_lo_r - cnt_lo_r;
      end
      if (rank_hi_r >= cnt_hi_r) begin
        pre_hi_r  <= pre_hi_r | bit_one;
        rank_hi_r <= rank_hi_r - cnt_hi_r;
      end
      cnt_lo_r <= '0;
      cnt_hi_r <= '0;
    end else if (cmd.acc) begin
      if (hit_lo) begin
        cnt_lo_r <= cnt_lo_r + 1'b1;
      end
      if (hit_hi) begin
        cnt_hi_r <= cnt_hi_r + 1'b1;
      end
    end
  end

  // Median, MAD, scaling and threshold
  assign thr_sum = {5'b0, med_r} + {1'b0, prod_r[PW-1:mmot_pkg::K_FRAC]};
  assign thr_sat = (thr_sum[VW+4:VW] != '0) ? {VW{1'b1}} : thr_sum[VW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.empty) begin
      med_r <= '0;
      mad_r <= '0;
      thr_r <= floor_r;
    end else begin
      if (cmd.set_med) begin
        med_r <= mid_sum[VW:1];
      end
      if (cmd.set_mad) begin
        mad_r <= mid_sum[VW:1];
      end
      if (cmd.mul) begin
        prod_r <= scale_r * mad_r;
      end
      if (cmd.thr) begin
        thr_r <= (thr_sat < floor_r) ? floor_r : thr_sat;
      end
    end
  end

  // Output register: load when free or being taken, drop on transfer
  assign cnt_ext = {{NW{1'b0}}, fill_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.threshold    <= thr_r;
      out_r.median_value <= med_r;
      out_r.mad_value    <= mad_r;
      out_r.sample_count <= cnt_ext[NW-1:0];
      out_r.overflow     <= ovf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign sts.fill_zero = (fill_r == '0);
  assign sts.addr_last = (rd_addr == fill_m1[AW-1:0]);
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

/* hdl/median_mad_outlier_threshold_core.sv */
// ----------------------------------------------------------------------------
// median_mad_outlier_threshold_core
// Robust outlier threshold from the median and MAD of a set of Q16.8 errors.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle into a single RAM of MAX_SAMPLES entries;
// samples beyond capacity are dropped and flagged. The item with last closes
// the set. The median and then the MAD are each found by 24 bitwise rank
// passes over the stored set, one RAM read per cycle; an empty set skips them.
// The input is stalled from the close of a set until the result is moved to
// the output register. The result then sits in an
// output register, so the next set can load while it waits to be taken.
// threshold = max(floor, median + (k * MAD) >> 12), saturated to 24 bits.
// ----------------------------------------------------------------------------
module median_mad_outlier_threshold_core #(
  parameter int MAX_SAMPLES = mmot_pkg::MAX_SAMPLES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mmot_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mmot_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [mmot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmot_pkg::VAL_W-1:0]     cfg_wdata
);

  mmot_pkg::dp_cmd_t              cmd;
  mmot_pkg::dp_sts_t              sts;
  logic [$clog2(MAX_SAMPLES)-1:0] rd_addr;
  logic                           in_accept;

  assign in_accept = in_valid && !in_stall;

  mmot_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  mmot_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .sts       (sts)
  );

  // A new result only appears after the sequencer has loaded it
  a_load_before_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("result appeared without a load");

  // No input transfer while selection passes run
  a_stall_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en || cmd.acc) |-> in_stall)
    else $error("input open during selection");

  // Threshold never falls below the median
  a_thr_ge_med: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.threshold >= out_data.median_value))
    else $error("threshold below median");

endmodule
